### src/ocd_pkg.sv
package ocd_pkg;

  localparam int RAW_W      = 16;
  localparam int AXIS_W     = 16;
  localparam int MAG_W      = 16;
  localparam int DIGIT_W    = 4;
  localparam int SUM_W      = 2 * MAG_W + 2;
  localparam int NUM_DIGITS = (SUM_W + DIGIT_W - 1) / DIGIT_W;
  localparam int DIG_CNT_W  = $clog2(NUM_DIGITS);
  localparam int DEFAULT_DEPTH = 16;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int FS_W       = 2;
  localparam int THR_W      = 16;

  localparam logic [0:0] REG_FULL_SCALE = 1'b0;
  localparam logic [0:0] REG_THRESHOLD  = 1'b1;

  localparam logic [FS_W-1:0] FS_2G  = 2'd0;
  localparam logic [FS_W-1:0] FS_4G  = 2'd1;
  localparam logic [FS_W-1:0] FS_8G  = 2'd2;
  localparam logic [FS_W-1:0] FS_16G = 2'd3;

  localparam logic [FS_W-1:0]  FULL_SCALE_RESET = FS_2G;
  localparam logic [THR_W-1:0] THRESHOLD_RESET  = 16'd250;

  typedef logic signed [AXIS_W-1:0] axis_t;

  typedef struct packed {
    axis_t x;
    axis_t y;
    axis_t z;
  } ring_entry_t;

  typedef struct packed {
    logic [FS_W-1:0]  full_scale;
    logic [THR_W-1:0] threshold;
  } cfg_t;

  function automatic axis_t scale_axis(input logic signed [RAW_W-1:0] raw,
                                       input logic [FS_W-1:0] fs);
    logic signed [7:0] steps;
    axis_t ext;
    axis_t res;
    steps = raw[15:8] + {7'd0, (raw[15] && (raw[7:0] != 8'd0))};
    ext = {{8{steps[7]}}, steps};
    case (fs)
      FS_2G:   res = ext <<< 4;
      FS_4G:   res = ext <<< 5;
      FS_8G:   res = ext <<< 6;
      FS_16G:  res = (ext <<< 6) + (ext <<< 7);
      default: res = ext <<< 4;
    endcase
    return res;
  endfunction

  function automatic logic [MAG_W-1:0] abs_diff(input axis_t a, input axis_t b);
    logic signed [AXIS_W:0] d;
    d = {a[AXIS_W-1], a} - {b[AXIS_W-1], b};
    if (d[AXIS_W]) begin
      d = -d;
    end
    return d[MAG_W-1:0];
  endfunction

endpackage

### src/ocd_in_if.sv
interface ocd_in_if
  import ocd_pkg::*;
();
  logic  valid;
  logic  ready;
  logic signed [RAW_W-1:0] raw_x;
  logic signed [RAW_W-1:0] raw_y;
  logic signed [RAW_W-1:0] raw_z;

  modport source (output valid, output raw_x, output raw_y, output raw_z, input ready);
  modport sink (input valid, input raw_x, input raw_y, input raw_z, output ready);
endinterface

### src/ocd_out_if.sv
interface ocd_out_if
  import ocd_pkg::*;
();
  logic  valid;
  logic  ready;
  axis_t scaled_x;
  axis_t scaled_y;
  axis_t scaled_z;
  logic  history_full;
  logic  over_threshold;
  logic  orientation_event;

  modport source (output valid, output scaled_x, output scaled_y, output scaled_z,
                  output history_full, output over_threshold, output orientation_event,
                  input ready);
  modport sink (input valid, input scaled_x, input scaled_y, input scaled_z,
                input history_full, input over_threshold, input orientation_event,
                output ready);
endinterface

### src/ocd_cfg.sv
module ocd_cfg
  import ocd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic       aligned;
  logic [0:0] reg_idx;
  logic       wr_fire;

  assign pready  = 1'b1;
  assign aligned = (paddr[1:0] == 2'd0);
  assign reg_idx = paddr[2];
  assign wr_fire = psel && penable && pwrite && pready && aligned;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.full_scale <= FULL_SCALE_RESET;
      cfg.threshold  <= THRESHOLD_RESET;
    end else if (wr_fire) begin
      case (reg_idx)
        REG_FULL_SCALE: cfg.full_scale <= pwdata[FS_W-1:0];
        REG_THRESHOLD:  cfg.threshold  <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (aligned) begin
      case (reg_idx)
        REG_FULL_SCALE: prdata = {{(CFG_DATA_W-FS_W){1'b0}}, cfg.full_scale};
        REG_THRESHOLD:  prdata = {{(CFG_DATA_W-THR_W){1'b0}}, cfg.threshold};
        default:        prdata = '0;
      endcase
    end
  end

endmodule

### src/ocd_ring.sv
module ocd_ring
  import ocd_pkg::*;
#(
  parameter int DEPTH  = DEFAULT_DEPTH,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  ring_entry_t       wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output ring_entry_t       rdata
);

  ring_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/ocd_sqmul.sv
module ocd_sqmul
  import ocd_pkg::*;
(
  input  logic               clk,
  input  logic               load,
  input  logic               step,
  input  logic [MAG_W-1:0]   a,
  output logic [DIGIT_W-1:0] digit
);

  logic [MAG_W-1:0]         mcand;
  logic [MAG_W-1:0]         mplier;
  logic [MAG_W-1:0]         acc;
  logic [MAG_W+DIGIT_W-1:0] partial;

  // emit the product least significant digit first
  assign partial = {{DIGIT_W{1'b0}}, acc} + mcand * mplier[DIGIT_W-1:0];
  assign digit   = partial[DIGIT_W-1:0];

  always_ff @(posedge clk) begin
    if (load) begin
      mcand  <= a;
      mplier <= a;
      acc    <= '0;
    end else if (step) begin
      mplier <= mplier >> DIGIT_W;
      acc    <= partial[MAG_W+DIGIT_W-1:DIGIT_W];
    end
  end

endmodule

### src/ocd_sumcmp.sv
module ocd_sumcmp
  import ocd_pkg::*;
(
  input  logic               clk,
  input  logic               clear,
  input  logic               step,
  input  logic [DIGIT_W-1:0] dx,
  input  logic [DIGIT_W-1:0] dy,
  input  logic [DIGIT_W-1:0] dz,
  input  logic [DIGIT_W-1:0] dt,
  output logic               gt
);

  logic [1:0]         carry;
  logic [DIGIT_W+1:0] sum;
  logic [DIGIT_W-1:0] sdig;

  assign sum  = {2'b00, dx} + {2'b00, dy} + {2'b00, dz} + {{DIGIT_W{1'b0}}, carry};
  assign sdig = sum[DIGIT_W-1:0];

  // a higher digit overrides the verdict of the lower ones
  always_ff @(posedge clk) begin
    if (clear) begin
      carry <= '0;
      gt    <= 1'b0;
    end else if (step) begin
      carry <= sum[DIGIT_W+1:DIGIT_W];
      gt    <= (sdig > dt) || ((sdig == dt) && gt);
    end
  end

endmodule

### src/accel_orientation_change_detector.sv
// Channel   Dir  Payload                                            Transfer
// samples   in   raw_x, raw_y, raw_z                                valid && ready
// results   out  scaled_x/y/z, history_full, over_threshold, event  valid && ready
// apb       in   full_scale_select @0x0, change_threshold_mg @0x4   psel, penable, pwrite
//
// Each sample passes through accept, ring read, 9 digit steps of the 4-bit
// serial squarers and summing comparator, then the result load.
// Reset clears the ring pointer, fill flag, event latch and result valid.
// A waiting result does not block the next sample; a stalled result holds
// the finished sample until the result register frees.
module accel_orientation_change_detector
  import ocd_pkg::*;
#(
  parameter int DEPTH = DEFAULT_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  ocd_in_if.sink                samples,
  ocd_out_if.source             results,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(DEPTH - 1);
  localparam logic [DIG_CNT_W-1:0] LAST_DIGIT = DIG_CNT_W'(NUM_DIGITS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]           state;
  logic [DIG_CNT_W-1:0] digit_cnt;
  logic [ADDR_W-1:0]    write_slot;
  logic                 ring_filled;
  logic                 event_latched;
  logic                 full_hold;
  ring_entry_t          cur;
  ring_entry_t          old;
  cfg_t                 cfg;

  logic                 res_valid;
  ring_entry_t          res_data;
  logic                 res_full;
  logic                 res_over;
  logic                 res_event;

  logic                 acc_fire;
  logic                 load;
  logic                 step;
  logic                 res_load;
  logic                 gt;
  logic                 over_now;
  logic [DIGIT_W-1:0]   dig_x;
  logic [DIGIT_W-1:0]   dig_y;
  logic [DIGIT_W-1:0]   dig_z;
  logic [DIGIT_W-1:0]   dig_t;

  ocd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign samples.ready = (state == ST_IDLE);
  assign acc_fire      = samples.valid && samples.ready;
  assign load          = (state == ST_READ);
  assign step          = (state == ST_MUL);
  assign res_load      = (state == ST_DONE) && (!res_valid || results.ready);
  assign over_now      = full_hold && gt;

  ocd_ring #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ring (
    .clk   (clk),
    .we    (load),
    .waddr (write_slot),
    .wdata (cur),
    .re    (acc_fire),
    .raddr (write_slot),
    .rdata (old)
  );

  ocd_sqmul u_sq_x (
    .clk (clk), .load (load), .step (step), .a (abs_diff(cur.x, old.x)), .digit (dig_x)
  );
  ocd_sqmul u_sq_y (
    .clk (clk), .load (load), .step (step), .a (abs_diff(cur.y, old.y)), .digit (dig_y)
  );
  ocd_sqmul u_sq_z (
    .clk (clk), .load (load), .step (step), .a (abs_diff(cur.z, old.z)), .digit (dig_z)
  );
  ocd_sqmul u_sq_t (
    .clk (clk), .load (load), .step (step), .a (cfg.threshold), .digit (dig_t)
  );

  ocd_sumcmp u_sumcmp (
    .clk   (clk),
    .clear (load),
    .step  (step),
    .dx    (dig_x),
    .dy    (dig_y),
    .dz    (dig_z),
    .dt    (dig_t),
    .gt    (gt)
  );

  always_ff @(posedge clk) begin
    if (acc_fire) begin
      cur.x     <= scale_axis(samples.raw_x, cfg.full_scale);
      cur.y     <= scale_axis(samples.raw_y, cfg.full_scale);
      cur.z     <= scale_axis(samples.raw_z, cfg.full_scale);
      full_hold <= ring_filled;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      digit_cnt     <= '0;
      write_slot    <= '0;
      ring_filled   <= 1'b0;
      event_latched <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (acc_fire) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          digit_cnt <= '0;
          state     <= ST_MUL;
          if (write_slot == LAST_SLOT) begin
            write_slot  <= '0;
            ring_filled <= 1'b1;
          end else begin
            write_slot <= write_slot + 1'b1;
          end
        end
        ST_MUL: begin
          digit_cnt <= digit_cnt + 1'b1;
          if (digit_cnt == LAST_DIGIT) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_load) begin
            state <= ST_IDLE;
            if (full_hold) begin
              event_latched <= gt;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_data  <= cur;
      res_full  <= full_hold;
      res_over  <= over_now;
      res_event <= over_now && !event_latched;
    end
  end

  assign results.valid             = res_valid;
  assign results.scaled_x          = res_data.x;
  assign results.scaled_y          = res_data.y;
  assign results.scaled_z          = res_data.z;
  assign results.history_full      = res_full;
  assign results.over_threshold    = res_over;
  assign results.orientation_event = res_event;

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    acc_fire |=> !samples.ready)
    else $error("sample taken while another is in progress");

  a_flag_order: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (!results.orientation_event || results.over_threshold) &&
                      (!results.over_threshold || results.history_full))
    else $error("result flags inconsistent");

  a_fill_sticky: assert property (@(posedge clk) disable iff (rst)
    ring_filled |=> ring_filled)
    else $error("ring fill flag dropped");

  a_latch_follows: assert property (@(posedge clk) disable iff (rst)
    (res_load && full_hold) |=> (event_latched == res_over))
    else $error("event latch out of step with result");

endmodule

### dv/accel_orientation_change_detector_tb.sv
module accel_orientation_change_detector_tb;
  import ocd_pkg::*;

  localparam int RING_DEPTH      = DEFAULT_DEPTH;
  localparam int STALL_LIMIT     = 2000;
  localparam int HOLD_CYCLES     = 80;
  localparam int DRAIN_CYCLES    = 30;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 50;

  localparam logic [CFG_ADDR_W-1:0] FS_ADDR  = {REG_FULL_SCALE, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] THR_ADDR = {REG_THRESHOLD, 2'b00};

  typedef logic signed [RAW_W-1:0] raw_t;

  typedef struct packed {
    raw_t x;
    raw_t y;
    raw_t z;
  } raw_sample_t;

  typedef struct packed {
    axis_t x;
    axis_t y;
    axis_t z;
    logic  full;
    logic  over;
    logic  evt;
  } change_result_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  ocd_in_if  samples ();
  ocd_out_if results ();

  accel_orientation_change_detector dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .results (results),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  raw_sample_t    pending_samples[$];
  change_result_t expected_changes[$];

  ring_entry_t      hist_ring [RING_DEPTH];
  int               hist_slot;
  logic             hist_filled;
  logic             latch_over;
  logic [FS_W-1:0]  cur_fs;
  logic [THR_W-1:0] cur_thr;

  int   base_steps [3];
  logic no_idle;
  logic in_xfer;
  int   send_gap;
  int   take_gap;
  int   hold_left;
  logic hold_done;
  int   quiet_cycles;

  int mismatches;
  int results_seen;
  int compares_seen;
  int overs_seen;
  int events_seen;
  int ties_seen;
  int configs_written;

  initial begin
    clk = 1'b0;
    forever begin
      #6 clk = ~clk;
    end
  end

  function automatic int mg_per_step(input logic [FS_W-1:0] fs);
    case (fs)
      FS_2G:   return 16;
      FS_4G:   return 32;
      FS_8G:   return 64;
      default: return 192;
    endcase
  endfunction

  function automatic axis_t to_milli_g(input raw_t raw, input logic [FS_W-1:0] fs);
    int steps;
    steps = int'(raw) / 256;
    return axis_t'(steps * mg_per_step(fs));
  endfunction

  function automatic longint sq_change(input axis_t a, input axis_t b);
    longint d;
    d = longint'(a) - longint'(b);
    return d * d;
  endfunction

  function automatic change_result_t next_change(input raw_sample_t s);
    change_result_t r;
    ring_entry_t    old_e;
    longint         mag2;
    longint         thr2;
    r.x    = to_milli_g(s.x, cur_fs);
    r.y    = to_milli_g(s.y, cur_fs);
    r.z    = to_milli_g(s.z, cur_fs);
    r.full = hist_filled;
    r.over = 1'b0;
    r.evt  = 1'b0;
    if (hist_filled) begin
      old_e = hist_ring[hist_slot];
      mag2  = sq_change(r.x, old_e.x) + sq_change(r.y, old_e.y) + sq_change(r.z, old_e.z);
      thr2  = longint'(cur_thr) * longint'(cur_thr);
      compares_seen++;
      if (mag2 == thr2) begin
        ties_seen++;
      end
      if (mag2 > thr2) begin
        r.over     = 1'b1;
        r.evt      = !latch_over;
        latch_over = 1'b1;
        overs_seen++;
        if (r.evt) begin
          events_seen++;
        end
      end else begin
        latch_over = 1'b0;
      end
    end
    hist_ring[hist_slot] = {r.x, r.y, r.z};
    hist_slot = (hist_slot + 1) % RING_DEPTH;
    if (hist_slot == 0) begin
      hist_filled = 1'b1;
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input logic signed [AXIS_W:0] want_v,
                                      input logic signed [AXIS_W:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
      mismatches++;
    end
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic void queue_sample(input raw_t x, input raw_t y, input raw_t z);
    pending_samples.push_back({x, y, z});
  endfunction

  // mostly slow drift around a base orientation, with nudges, jumps and raw noise
  task automatic queue_random_samples(input int count);
    int   k;
    int   a;
    int   r;
    int   low;
    raw_t v [3];
    for (k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        a = $urandom_range(0, 2);
        base_steps[a] = base_steps[a] + int'($urandom_range(0, 12)) - 6;
        if (base_steps[a] > 127) begin
          base_steps[a] = 127;
        end
        if (base_steps[a] < -128) begin
          base_steps[a] = -128;
        end
      end else if (r < 32) begin
        for (a = 0; a < 3; a++) begin
          base_steps[a] = int'($urandom_range(0, 255)) - 128;
        end
      end
      for (a = 0; a < 3; a++) begin
        if (r >= 88) begin
          v[a] = raw_t'($urandom);
        end else begin
          low  = ($urandom_range(0, 1) == 1) ? int'($urandom_range(0, 255)) : 0;
          v[a] = raw_t'(base_steps[a] * 256 + low);
        end
      end
      queue_sample(v[0], v[1], v[2]);
    end
  endtask

  task automatic apb_write(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // upper data bits are random and must be dropped by the register
  task automatic apply_config(input logic [FS_W-1:0] fs, input logic [THR_W-1:0] thr);
    logic [CFG_DATA_W-1:0] fs_word;
    logic [CFG_DATA_W-1:0] thr_word;
    fs_word  = $urandom;
    thr_word = $urandom;
    fs_word[FS_W-1:0]   = fs;
    thr_word[THR_W-1:0] = thr;
    apb_write(FS_ADDR, fs_word);
    apb_write(THR_ADDR, thr_word);
    cur_fs  = fs;
    cur_thr = thr;
    configs_written++;
  endtask

  // check at the rising edge, once the driver's falling-edge updates have settled
  task automatic wait_idle();
    while (pending_samples.size() != 0 || samples.valid || expected_changes.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  always @(negedge clk) begin : drive_samples
    raw_sample_t nxt;
    if (rst) begin
      samples.valid <= 1'b0;
      send_gap      <= 0;
    end else if (samples.valid && !in_xfer) begin
      // hold until the transfer completes
    end else if (send_gap != 0) begin
      samples.valid <= 1'b0;
      send_gap      <= send_gap - 1;
    end else if (pending_samples.size() != 0) begin
      nxt = pending_samples.pop_front();
      samples.valid <= 1'b1;
      samples.raw_x <= nxt.x;
      samples.raw_y <= nxt.y;
      samples.raw_z <= nxt.z;
      send_gap      <= pick_gap();
    end else begin
      samples.valid <= 1'b0;
    end
  end

  always @(negedge clk) begin : drive_ready
    if (rst) begin
      results.ready <= 1'b0;
      take_gap      <= 0;
      hold_left     <= 0;
      hold_done     <= 1'b0;
    end else if (hold_left != 0) begin
      results.ready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (!hold_done && results_seen >= 100 && pending_samples.size() > 10) begin
      // hold off long enough for the block to back up onto its input
      results.ready <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      hold_done     <= 1'b1;
    end else if (take_gap != 0) begin
      results.ready <= 1'b0;
      take_gap      <= take_gap - 1;
    end else begin
      results.ready <= 1'b1;
      take_gap      <= pick_gap();
    end
  end

  always @(posedge clk) begin : watch_channels
    change_result_t want;
    change_result_t got;
    if (rst) begin
      in_xfer <= 1'b0;
    end else begin
      in_xfer <= samples.valid && samples.ready;
      if (samples.valid && samples.ready) begin
        expected_changes.push_back(
          next_change({samples.raw_x, samples.raw_y, samples.raw_z}));
      end
      if (results.valid && results.ready) begin
        got = {results.scaled_x, results.scaled_y, results.scaled_z,
               results.history_full, results.over_threshold, results.orientation_event};
        results_seen++;
        if (expected_changes.size() == 0) begin
          $display("%0t: result transfer with nothing expected, got %p", $time, got);
          mismatches++;
        end else begin
          want = expected_changes.pop_front();
          check_field("scaled_x", want.x, got.x);
          check_field("scaled_y", want.y, got.y);
          check_field("scaled_z", want.z, got.z);
          check_field("history_full", want.full, got.full);
          check_field("over_threshold", want.over, got.over);
          check_field("orientation_event", want.evt, got.evt);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (samples.valid && samples.ready) || (results.valid && results.ready)
        || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : run_test
    int               p;
    int               k;
    logic [FS_W-1:0]  fs;
    logic [THR_W-1:0] thr;
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    samples.valid = 1'b0;
    samples.raw_x = '0;
    samples.raw_y = '0;
    samples.raw_z = '0;
    results.ready = 1'b0;
    no_idle       = 1'b0;
    quiet_cycles  = 0;
    hist_slot     = 0;
    hist_filled   = 1'b0;
    latch_over    = 1'b0;
    cur_fs        = FULL_SCALE_RESET;
    cur_thr       = THRESHOLD_RESET;
    for (k = 0; k < 3; k++) begin
      base_steps[k] = 0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // fill the ring with extremes and truncation corners under reset settings
    queue_sample(16'sh8000, 16'sh7FFF, 16'sh0000);
    queue_sample(16'sh7FFF, 16'sh8000, 16'shFFFF);
    queue_sample(raw_t'(-255), raw_t'(-256), raw_t'(-257));
    queue_sample(raw_t'(255), raw_t'(256), raw_t'(257));
    queue_sample(16'sh5555, 16'shAAAA, 16'sh00FF);
    queue_sample(16'sh1234, 16'shEDCC, 16'sh0100);
    for (k = 6; k < RING_DEPTH; k++) begin
      queue_sample(raw_t'($urandom), raw_t'($urandom), raw_t'($urandom));
    end
    // no change, first jump, sustained jump, back to quiet, new jump, small step
    queue_sample(16'sh8000, 16'sh7FFF, 16'sh0000);
    queue_sample(16'sh8000, 16'sh7FFF, 16'sh0000);
    queue_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    queue_sample(raw_t'(255), raw_t'(256), raw_t'(257));
    queue_sample(16'shAAAA, 16'sh5555, 16'shFF00);
    queue_sample(16'sh1334, 16'shEDCC, 16'sh0100);
    wait_idle();

    for (p = 0; p < PHASES; p++) begin
      case (p % 4)
        0:       fs = FS_16G;
        1:       fs = FS_2G;
        2:       fs = FS_8G;
        default: fs = FS_4G;
      endcase
      if (p == 0) begin
        thr = '0;
      end else if (p == 1) begin
        thr = '1;
      end else if (p % 2 == 0) begin
        // whole steps so that a change can land level with the threshold
        thr = THR_W'(mg_per_step(fs) * int'($urandom_range(1, 6)));
      end else begin
        thr = THR_W'($urandom_range(100, 4000));
      end
      no_idle = (p == 3 || p == 6);
      apply_config(fs, thr);
      queue_random_samples(ITEMS_PER_PHASE);
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d results across %0d register settings after reset defaults.",
             results_seen, configs_written);
    $display("History compares %0d, over threshold %0d, events %0d, level with threshold %0d.",
             compares_seen, overs_seen, events_seen, ties_seen);
    if (mismatches == 0 && expected_changes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
